FILE: rtl/core/knr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package knr_pkg;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INIT_DIV,
      ST_INIT_WAIT,
      ST_TEST,
      ST_PREP,
      ST_POW_P,
      ST_POW_P_WAIT,
      ST_POW_PP,
      ST_POW_PP_WAIT,
      ST_POW_PM,
      ST_POW_PM_WAIT,
      ST_DERIV,
      ST_STEP_MUL,
      ST_STEP_MUL_WAIT,
      ST_STEP_DIV,
      ST_STEP_DIV_WAIT,
      ST_UPDATE,
      ST_RECIP,
      ST_RECIP_WAIT,
      ST_DONE
   } state_type;

   // which operand set the shared units work on
   typedef enum logic [1:0] {
      POW_X,
      POW_XP,
      POW_XM
   } pow_sel_type;

   typedef enum logic [1:0] {
      DIV_INIT,
      DIV_STEP,
      DIV_RECIP
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        test;
      logic        prep;
      logic        pow_start;
      pow_sel_type pow_sel;
      logic        deriv;
      logic        mul_start;
      logic        div_start;
      div_sel_type div_sel;
      logic        update;
      logic        recip_zero;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic bad_order;
      logic neg;
      logic conv;
      logic limit_hit;
      logic deriv_zero;
      logic x_zero;
      logic pow_done;
      logic mul_done;
      logic div_done;
   } sts_type;

   localparam int CFG_STEP_SIZE = 0;
   localparam int CFG_TOLERANCE = 1;
   localparam int CFG_ITER_LIMIT = 2;

endpackage
`default_nettype wire

FILE: rtl/core/knr_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// 64x64 -> 128 product, four 32x32 partial products one per cycle
module knr_mul (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [63:0]  op_a,
   input  wire logic [63:0]  op_b,
   output logic              done,
   output logic [127:0]      product
);
   logic [63:0]  a_ff, b_ff;
   logic [127:0] acc_ff;
   logic [2:0]   cnt_ff;
   logic         busy_ff, done_ff;
   logic [31:0]  pa, pb;
   logic [63:0]  pp;
   logic [127:0] sh;

   always_comb begin
      pa = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      pb = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp = pa * pb;
      sh = {64'd0, pp} << ({6'd0, cnt_ff[1]} + {6'd0, cnt_ff[0]}) * 7'd32;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= op_a;
         b_ff   <= op_b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_ff + sh;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

FILE: rtl/core/knr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// 128/64 restoring division, one quotient bit per cycle, saturating
module knr_div (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [127:0] num,
   input  wire logic [63:0]  den,
   output logic              done,
   output logic [63:0]       quot,
   output logic              sat
);
   logic [63:0] r_ff, lo_ff, q_ff, d_ff;
   logic [6:0]  cnt_ff;
   logic        busy_ff, done_ff, sat_ff;
   logic [64:0] r_sh;
   logic        ge;

   always_comb begin
      r_sh = {r_ff, lo_ff[63]};
      ge   = r_sh >= {1'b0, d_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (num[127:64] >= den) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         r_ff   <= num[127:64];
         lo_ff  <= num[63:0];
         d_ff   <= den;
         sat_ff <= num[127:64] >= den;
         q_ff   <= '1;
      end else if (busy_ff) begin
         lo_ff <= {lo_ff[62:0], 1'b0};
         if (ge) begin
            r_ff <= r_sh[63:0] - d_ff;
            q_ff <= {q_ff[62:0], 1'b1};
         end else begin
            r_ff <= r_sh[63:0];
            q_ff <= {q_ff[62:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign sat  = sat_ff;
endmodule
`default_nettype wire

FILE: rtl/core/knr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module knr_datapath #(
   parameter int MAX_ORDER = 16,
   parameter int FRAC_BITS = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  knr_pkg::cmd_type     cmd,
   output knr_pkg::sts_type     sts,
   input  wire logic [63:0]     req_radicand,
   input  wire logic [5:0]      req_root_order,
   input  wire logic [15:0]     step_size,
   input  wire logic [15:0]     tolerance,
   input  wire logic [11:0]     iteration_limit,
   output logic [63:0]          root_value,
   output logic                 converged,
   output logic [11:0]          iterations_used,
   output logic                 error_flag
);
   localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
   localparam logic [127:0] ONE_SQ = 128'd1 << (2 * FRAC_BITS);

   logic [63:0] a_ff, xn_ff, xn1_ff, xp_ff, xm_ff;
   logic [63:0] p_ff, pp_ff, pm_ff, d_ff, f_ff, acc_ff, base_ff;
   logic [5:0]  mag_ff, pcnt_ff;
   logic        neg_ff, bad_ff, fpos_ff, err_ff, conv_ff, pbusy_ff, pdone_ff;
   logic        pmul_ff;
   logic [11:0] used_ff;
   logic [5:0]  mag;
   logic        mstart, mdone, dstart, ddone, dsat;
   logic [63:0] ma, mb, dden, dq, diff;
   logic [127:0] mprod, dnum;
   logic [64:0] xp_sum, up_sum;

   assign mag = req_root_order[5] ? 6'd0 - req_root_order : req_root_order;

   // multiplier shared between power chains and the step numerator
   assign mstart = pmul_ff | cmd.mul_start;
   assign ma     = pbusy_ff ? acc_ff : {47'd0, step_size, 1'b0};
   assign mb     = pbusy_ff ? base_ff : f_ff;
   knr_mul u_mul (
      .clock(clock), .reset(reset), .start(mstart), .op_a(ma), .op_b(mb),
      .done(mdone), .product(mprod)
   );

   always_comb begin
      priority case (cmd.div_sel)
         knr_pkg::DIV_INIT: begin
            dnum = {64'd0, a_ff};
            dden = {58'd0, mag_ff};
         end
         knr_pkg::DIV_STEP: begin
            dnum = mprod;
            dden = d_ff;
         end
         default: begin
            dnum = ONE_SQ;
            dden = xn_ff;
         end
      endcase
   end
   assign dstart = cmd.div_start;
   knr_div u_div (
      .clock(clock), .reset(reset), .start(dstart), .num(dnum), .den(dden),
      .done(ddone), .quot(dq), .sat(dsat)
   );

   assign diff   = xn1_ff > xn_ff ? xn1_ff - xn_ff : xn_ff - xn1_ff;
   assign xp_sum = {1'b0, xn1_ff} + {49'd0, step_size};
   assign up_sum = {1'b0, xn_ff} + {1'b0, dq};

   always_ff @(posedge clock) begin
      if (reset) begin
         pbusy_ff <= 1'b0;
         pdone_ff <= 1'b0;
         pmul_ff  <= 1'b0;
      end else begin
         pdone_ff <= 1'b0;
         pmul_ff  <= 1'b0;
         if (cmd.pow_start) begin
            if (mag_ff == 6'd0) begin
               pdone_ff <= 1'b1;
            end else begin
               pbusy_ff <= 1'b1;
               pmul_ff  <= 1'b1;
            end
         end else if (pbusy_ff && mdone) begin
            if (pcnt_ff == mag_ff - 6'd1) begin
               pbusy_ff <= 1'b0;
               pdone_ff <= 1'b1;
            end else begin
               pmul_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff    <= req_radicand;
         xn1_ff  <= req_radicand;
         mag_ff  <= mag;
         neg_ff  <= req_root_order[5];
         bad_ff  <= mag == 6'd0 || {26'd0, mag} > MAX_ORDER;
         err_ff  <= 1'b0;
         conv_ff <= 1'b0;
         used_ff <= '0;
      end
      if (ddone && cmd.div_sel == knr_pkg::DIV_INIT) begin
         xn_ff <= dq;
      end
      if (cmd.test) begin
         conv_ff <= diff <= {48'd0, tolerance};
      end
      if (cmd.prep) begin
         xn_ff <= xn1_ff;
         xp_ff <= xp_sum[64] ? '1 : xp_sum[63:0];
         xm_ff <= xn1_ff < {48'd0, step_size} ? '0 : xn1_ff - {48'd0, step_size};
      end
      if (cmd.pow_start) begin
         acc_ff  <= ONE;
         pcnt_ff <= '0;
         priority case (cmd.pow_sel)
            knr_pkg::POW_X:  base_ff <= xn_ff;
            knr_pkg::POW_XP: base_ff <= xp_ff;
            default:         base_ff <= xm_ff;
         endcase
      end else if (pbusy_ff && mdone) begin
         pcnt_ff <= pcnt_ff + 6'd1;
         if (mprod[127:64+FRAC_BITS] != '0) begin
            acc_ff <= '1;
            err_ff <= 1'b1;
         end else begin
            acc_ff <= mprod[63+FRAC_BITS:FRAC_BITS];
         end
      end
      if (pdone_ff) begin
         priority case (cmd.pow_sel)
            knr_pkg::POW_X:  p_ff  <= acc_ff;
            knr_pkg::POW_XP: pp_ff <= acc_ff;
            default:         pm_ff <= acc_ff;
         endcase
      end
      if (cmd.deriv) begin
         d_ff    <= pp_ff - pm_ff;
         fpos_ff <= p_ff >= a_ff;
         f_ff    <= p_ff >= a_ff ? p_ff - a_ff : a_ff - p_ff;
         if (pp_ff <= pm_ff) err_ff <= 1'b1;
      end
      if (ddone && cmd.div_sel != knr_pkg::DIV_INIT && dsat) begin
         err_ff <= 1'b1;
      end
      if (cmd.update) begin
         used_ff <= used_ff + 12'd1;
         if (fpos_ff) xn1_ff <= xn_ff < dq ? '0 : xn_ff - dq;
         else         xn1_ff <= up_sum[64] ? '1 : up_sum[63:0];
      end
      if (ddone && cmd.div_sel == knr_pkg::DIV_RECIP) begin
         xn_ff <= dq;
      end
      if (cmd.recip_zero) begin
         xn_ff  <= '1;
         err_ff <= 1'b1;
      end
      if (cmd.finish && bad_ff) begin
         xn_ff  <= '0;
         err_ff <= 1'b1;
      end
   end

   always_comb begin
      sts.bad_order  = bad_ff;
      sts.neg        = neg_ff;
      sts.conv       = diff <= {48'd0, tolerance};
      sts.limit_hit  = used_ff >= iteration_limit;
      sts.deriv_zero = pp_ff <= pm_ff;
      sts.x_zero     = xn_ff == '0;
      sts.pow_done   = pdone_ff;
      sts.mul_done   = mdone && !pbusy_ff;
      sts.div_done   = ddone;
   end

   assign root_value      = xn_ff;
   assign converged       = conv_ff;
   assign iterations_used = used_ff;
   assign error_flag      = err_ff;
endmodule
`default_nettype wire

FILE: rtl/core/knr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module knr_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output knr_pkg::cmd_type       cmd,
   input  knr_pkg::sts_type       sts
);
   knr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= knr_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.pow_sel = knr_pkg::POW_X;
      cmd.div_sel = knr_pkg::DIV_INIT;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         knr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = knr_pkg::ST_INIT_DIV;
            end
         end
         knr_pkg::ST_INIT_DIV: begin
            if (sts.bad_order) begin
               cmd.finish = 1'b1;
               state_in   = knr_pkg::ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = knr_pkg::ST_INIT_WAIT;
            end
         end
         knr_pkg::ST_INIT_WAIT: if (sts.div_done) state_in = knr_pkg::ST_TEST;
         knr_pkg::ST_TEST: begin
            cmd.test = 1'b1;
            if (sts.conv || sts.limit_hit) state_in = knr_pkg::ST_RECIP;
            else                          state_in = knr_pkg::ST_PREP;
         end
         knr_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = knr_pkg::ST_POW_P;
         end
         knr_pkg::ST_POW_P: begin
            cmd.pow_start = 1'b1;
            state_in      = knr_pkg::ST_POW_P_WAIT;
         end
         knr_pkg::ST_POW_P_WAIT: if (sts.pow_done) state_in = knr_pkg::ST_POW_PP;
         knr_pkg::ST_POW_PP: begin
            cmd.pow_sel   = knr_pkg::POW_XP;
            cmd.pow_start = 1'b1;
            state_in      = knr_pkg::ST_POW_PP_WAIT;
         end
         knr_pkg::ST_POW_PP_WAIT: begin
            cmd.pow_sel = knr_pkg::POW_XP;
            if (sts.pow_done) state_in = knr_pkg::ST_POW_PM;
         end
         knr_pkg::ST_POW_PM: begin
            cmd.pow_sel   = knr_pkg::POW_XM;
            cmd.pow_start = 1'b1;
            state_in      = knr_pkg::ST_POW_PM_WAIT;
         end
         knr_pkg::ST_POW_PM_WAIT: begin
            cmd.pow_sel = knr_pkg::POW_XM;
            if (sts.pow_done) state_in = knr_pkg::ST_DERIV;
         end
         knr_pkg::ST_DERIV: begin
            cmd.deriv = 1'b1;
            // a flat derivative ends the search on the current iterate
            if (sts.deriv_zero) state_in = knr_pkg::ST_RECIP;
            else                state_in = knr_pkg::ST_STEP_MUL;
         end
         knr_pkg::ST_STEP_MUL: begin
            cmd.mul_start = 1'b1;
            state_in      = knr_pkg::ST_STEP_MUL_WAIT;
         end
         knr_pkg::ST_STEP_MUL_WAIT: if (sts.mul_done) state_in = knr_pkg::ST_STEP_DIV;
         knr_pkg::ST_STEP_DIV: begin
            cmd.div_sel   = knr_pkg::DIV_STEP;
            cmd.div_start = 1'b1;
            state_in      = knr_pkg::ST_STEP_DIV_WAIT;
         end
         knr_pkg::ST_STEP_DIV_WAIT: begin
            cmd.div_sel = knr_pkg::DIV_STEP;
            if (sts.div_done) state_in = knr_pkg::ST_UPDATE;
         end
         knr_pkg::ST_UPDATE: begin
            cmd.div_sel = knr_pkg::DIV_STEP;
            cmd.update  = 1'b1;
            state_in    = knr_pkg::ST_TEST;
         end
         knr_pkg::ST_RECIP: begin
            cmd.div_sel = knr_pkg::DIV_RECIP;
            if (!sts.neg) begin
               state_in = knr_pkg::ST_DONE;
            end else if (sts.x_zero) begin
               cmd.recip_zero = 1'b1;
               state_in       = knr_pkg::ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = knr_pkg::ST_RECIP_WAIT;
            end
         end
         knr_pkg::ST_RECIP_WAIT: begin
            cmd.div_sel = knr_pkg::DIV_RECIP;
            if (sts.div_done) state_in = knr_pkg::ST_DONE;
         end
         knr_pkg::ST_DONE: begin
            cmd.div_sel = knr_pkg::DIV_RECIP;
            rsp_valid   = 1'b1;
            if (!rsp_stall) state_in = knr_pkg::ST_IDLE;
         end
         default: state_in = knr_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/core/kth_root_newton.sv
`timescale 1ns / 1ps
`default_nettype none
// power multiplies run on the shared multiplier, which builds each 64x64 product from
// 32x32 partial products; divisions run on the bit-serial divider, and a negative order
// adds a reciprocal division; one item is processed at a time
// the result stays until the transfer completes
// reset (synchronous, active high): step_size and tolerance 4295, iteration_limit 1000
module kth_root_newton #(
   parameter int MAX_ORDER = 16,
   parameter int FRAC_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_radicand,
   input  wire logic [5:0]  req_root_order,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_root_value,
   output logic             rsp_converged,
   output logic [11:0]      rsp_iterations_used,
   output logic             rsp_error_flag,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   logic [15:0] step_ff, tol_ff;
   logic [11:0] limit_ff;
   knr_pkg::cmd_type cmd;
   knr_pkg::sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 16'd4295;
         tol_ff   <= 16'd4295;
         limit_ff <= 12'd1000;
      end else if (csr_write) begin
         if (csr_index == 2'(knr_pkg::CFG_STEP_SIZE))  step_ff  <= csr_data;
         if (csr_index == 2'(knr_pkg::CFG_TOLERANCE))  tol_ff   <= csr_data;
         if (csr_index == 2'(knr_pkg::CFG_ITER_LIMIT)) limit_ff <= csr_data[11:0];
      end
   end

   knr_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .cmd(cmd), .sts(sts)
   );

   knr_datapath #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_radicand(req_radicand), .req_root_order(req_root_order),
      .step_size(step_ff), .tolerance(tol_ff), .iteration_limit(limit_ff),
      .root_value(rsp_root_value), .converged(rsp_converged),
      .iterations_used(rsp_iterations_used), .error_flag(rsp_error_flag)
   );

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_root_value))
      else $error("result changed while stalled");
   a_conv_not_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_converged |-> rsp_iterations_used <= limit_ff)
      else $error("converged past the iteration limit");
endmodule
`default_nettype wire
